// File: hdl/rtts_pkg.sv
`timescale 1ns / 1ps
// Shared constants and types for the round-trip time statistics block.
package rtts_pkg;

	// Field and accumulator widths
	localparam int COUNT_BITS     = 16;
	localparam int DELAY_BITS     = 24;
	localparam int SUM_BITS       = 40;
	localparam int SQ_BITS        = 64;
	localparam int OUT_COUNT_BITS = 16;
	localparam int OUT_DELAY_BITS = 24;

	// Event kinds on the input channel
	localparam logic KIND_REQUEST = 1'b0;
	localparam logic KIND_REPLY   = 1'b1;

	// Variance datapath: n * sum_sq and sum^2 need COUNT_BITS + SQ_BITS bits
	localparam int PROD_BITS = COUNT_BITS + SQ_BITS;
	localparam int MUL_BITS  = 32;
	localparam int HALF_BITS = SUM_BITS / 2;

	// Shared divider: remainder and divisor hold n^2, quotient holds a squared delay
	localparam int DIV_BITS     = 2 * COUNT_BITS;
	localparam int QUO_BITS     = 2 * DELAY_BITS;
	localparam int DIV_CNT_BITS = $clog2(QUO_BITS + 1);

	// Queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

	// Statistics after one item
	typedef struct packed {
		logic [COUNT_BITS-1:0] sent;
		logic [COUNT_BITS-1:0] recv;
		logic [DELAY_BITS-1:0] min_d;
		logic [DELAY_BITS-1:0] max_d;
		logic [SUM_BITS-1:0]   sum;
		logic [SQ_BITS-1:0]    sq_sum;
	} snap_t;

	// Request to the shared divider
	typedef struct packed {
		logic                    start;
		logic [DIV_BITS-1:0]     rem_init;
		logic [QUO_BITS-1:0]     dividend;
		logic [DIV_BITS-1:0]     divisor;
		logic [DIV_CNT_BITS-1:0] steps;
	} div_req_t;

	// Status and result of the shared divider
	typedef struct packed {
		logic                busy;
		logic                done;
		logic [QUO_BITS-1:0] quot;
	} div_rsp_t;

endpackage

// File: hdl/round_trip_time_statistics.sv
`timescale 1ns / 1ps
// Round-trip time statistics top level. Each input transfer is either a request-sent event
// (kind 0) or a reply with its delay in microseconds (kind 1), and each one yields exactly one
// result transfer with the saturating sent and received counts, the minimum and maximum delay,
// the truncated mean and the integer population standard deviation. The front takes one event
// a cycle, while the snapshot queue has room, into a two-entry snapshot queue; the back then
// handles one snapshot at a time. Before the first reply a snapshot goes straight to the result
// register; afterwards the back runs the single 32 x 32 multiplier for n * sum_sq, sum^2 and n^2,
// one subtract, a 24-step mean divide and a 48-step variance divide on the shared one-bit-a-cycle
// divider, and a 24-step square root. The back takes a new snapshot only once it is through with
// the last one, and up to three further events are absorbed while the back is busy.
module round_trip_time_statistics (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic                                kind,
	input  logic [rtts_pkg::DELAY_BITS-1:0]     delay_us,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rtts_pkg::OUT_COUNT_BITS-1:0] sent_count,
	output logic [rtts_pkg::OUT_COUNT_BITS-1:0] received_count,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] min_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] max_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] mean_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] stddev_delay_us
);
	import rtts_pkg::*;

	logic     push;
	logic     pop;
	logic     full;
	logic     empty;
	snap_t    wr_snap;
	snap_t    rd_snap;
	div_req_t div_req;
	div_rsp_t div_rsp;

	// Accept and total up events
	rtts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.kind     (kind),
		.delay_us (delay_us),
		.push     (push),
		.snap     (wr_snap),
		.full     (full)
	);

	// Decouple front from back
	rtts_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_snap),
		.full    (full),
		.pop     (pop),
		.rd_data (rd_snap),
		.empty   (empty)
	);

	// Shared divider for mean and variance
	rtts_divider u_divider (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// Derive statistics and drive the result channel
	rtts_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.empty           (empty),
		.rd_data         (rd_snap),
		.pop             (pop),
		.div_req         (div_req),
		.div_rsp         (div_rsp),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sent_count      (sent_count),
		.received_count  (received_count),
		.min_delay_us    (min_delay_us),
		.max_delay_us    (max_delay_us),
		.mean_delay_us   (mean_delay_us),
		.stddev_delay_us (stddev_delay_us)
	);

endmodule

// File: hdl/rtts_front.sv
`timescale 1ns / 1ps
// Front part: accepts events, squares the delay and updates the running totals.
module rtts_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic                             kind,
	input  logic [rtts_pkg::DELAY_BITS-1:0]  delay_us,
	output logic                             push,
	output rtts_pkg::snap_t                  snap,
	input  logic                             full
);
	import rtts_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

	logic                    accept;
	logic                    v_s1;
	logic                    kind_s1;
	logic [DELAY_BITS-1:0]   d_s1;
	logic [QUO_BITS-1:0]     sq_s1;
	snap_t                   st_q;
	snap_t                   nxt;
	logic [SUM_BITS:0]       sum_add;
	logic [SQ_BITS:0]        sq_add;

	// Hold the input while the update stage cannot pass its snapshot on
	assign in_stall = v_s1 & full;
	assign accept   = in_valid & ~in_stall;
	assign push     = v_s1 & ~full;

	// Stage one valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (push) begin
			v_s1 <= 1'b0;
		end
	end

	// Capture the event and square its delay
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind;
			d_s1    <= delay_us;
			sq_s1   <= QUO_BITS'(delay_us) * QUO_BITS'(delay_us);
		end
	end

	// Saturating sums
	assign sum_add = {1'b0, st_q.sum} + (SUM_BITS + 1)'(d_s1);
	assign sq_add  = {1'b0, st_q.sq_sum} + (SQ_BITS + 1)'(sq_s1);

	// Work out the totals after this event
	always_comb begin
		nxt = st_q;
		if (kind_s1 == KIND_REQUEST) begin
			if (st_q.sent != COUNT_MAX) begin
				nxt.sent = st_q.sent + 1'b1;
			end
		end else begin
			if (st_q.recv == '0) begin
				nxt.min_d = d_s1;
				nxt.max_d = d_s1;
			end else begin
				if (d_s1 < st_q.min_d) begin
					nxt.min_d = d_s1;
				end
				if (d_s1 > st_q.max_d) begin
					nxt.max_d = d_s1;
				end
			end
			// Leave the sums alone once the reply count has saturated
			if (st_q.recv != COUNT_MAX) begin
				nxt.recv   = st_q.recv + 1'b1;
				nxt.sum    = sum_add[SUM_BITS] ? '1 : sum_add[SUM_BITS-1:0];
				nxt.sq_sum = sq_add[SQ_BITS] ? '1 : sq_add[SQ_BITS-1:0];
			end
		end
	end

	assign snap = nxt;

	// Commit the totals as the snapshot is transferred to the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (push) begin
			st_q <= nxt;
		end
	end

endmodule

// File: hdl/rtts_queue.sv
`timescale 1ns / 1ps
// Short snapshot queue between the front and the back parts.
module rtts_queue (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  rtts_pkg::snap_t wr_data,
	output logic            full,
	input  logic            pop,
	output rtts_pkg::snap_t rd_data,
	output logic            empty
);
	import rtts_pkg::*;

	localparam logic [QPTR_BITS-1:0] PTR_LAST  = QPTR_BITS'(QUEUE_DEPTH - 1);
	localparam logic [QPTR_BITS:0]   CNT_FULL  = (QPTR_BITS + 1)'(QUEUE_DEPTH);

	snap_t                 mem_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0]  wr_ptr_q;
	logic [QPTR_BITS-1:0]  rd_ptr_q;
	logic [QPTR_BITS:0]    count_q;

	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign rd_data = mem_q[rd_ptr_q];

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("snapshot pushed into a full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty) else $error("snapshot popped from an empty queue");
`endif

endmodule

// File: hdl/rtts_divider.sv
`timescale 1ns / 1ps
// Shared restoring divider, one quotient bit per cycle.
module rtts_divider (
	input  logic               clk,
	input  logic               arst_n,
	input  rtts_pkg::div_req_t req,
	output rtts_pkg::div_rsp_t rsp
);
	import rtts_pkg::*;

	logic                    busy_q;
	logic                    done_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [DIV_BITS-1:0]     rem_q;
	logic [DIV_BITS-1:0]     dvs_q;
	logic [QUO_BITS-1:0]     dvd_q;
	logic [QUO_BITS-1:0]     quo_q;
	logic [DIV_BITS:0]       trial;
	logic                    q_bit;
	logic [DIV_BITS:0]       diff;

	// Shift in the next dividend bit and try the subtraction
	assign trial = {rem_q, dvd_q[QUO_BITS-1]};
	assign q_bit = (trial >= {1'b0, dvs_q});
	assign diff  = trial - {1'b0, dvs_q};

	// Sequence the steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= req.steps - 1'b1;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Load operands or take one step; the remainder stays below the divisor
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem_init;
			dvs_q <= req.divisor;
			dvd_q <= req.dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= q_bit ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
			dvd_q <= {dvd_q[QUO_BITS-2:0], 1'b0};
			quo_q <= {quo_q[QUO_BITS-2:0], q_bit};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// File: hdl/rtts_back.sv
`timescale 1ns / 1ps
// Back part: works out mean and standard deviation from each snapshot and holds the result.
module rtts_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                empty,
	input  rtts_pkg::snap_t                     rd_data,
	output logic                                pop,
	output rtts_pkg::div_req_t                  div_req,
	input  rtts_pkg::div_rsp_t                  div_rsp,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [rtts_pkg::OUT_COUNT_BITS-1:0] sent_count,
	output logic [rtts_pkg::OUT_COUNT_BITS-1:0] received_count,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] min_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] max_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] mean_delay_us,
	output logic [rtts_pkg::OUT_DELAY_BITS-1:0] stddev_delay_us
);
	import rtts_pkg::*;

	// Sequencer states
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_SUB  = 3'd2;
	localparam logic [2:0] ST_MEAN = 3'd3;
	localparam logic [2:0] ST_VAR  = 3'd4;
	localparam logic [2:0] ST_SQRT = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	// Partial products through the shared multiplier
	localparam logic [2:0] MUL_A_LO = 3'd0;
	localparam logic [2:0] MUL_A_HI = 3'd1;
	localparam logic [2:0] MUL_B_LL = 3'd2;
	localparam logic [2:0] MUL_B_LH = 3'd3;
	localparam logic [2:0] MUL_B_HH = 3'd4;
	localparam logic [2:0] MUL_NSQ  = 3'd5;
	localparam logic [2:0] MUL_END  = 3'd6;

	localparam int SQRT_STEPS    = QUO_BITS / 2;
	localparam int SQRT_CNT_BITS = $clog2(SQRT_STEPS);
	localparam int SREM_BITS     = DELAY_BITS + 2;
	localparam logic [SQRT_CNT_BITS-1:0] SQRT_LAST = SQRT_CNT_BITS'(SQRT_STEPS - 1);

	logic [2:0]               state_q;
	logic [2:0]               mul_idx_q;
	logic                     pv_s1;
	logic [2:0]               tag_s1;
	logic [2*MUL_BITS-1:0]    prod_s1;
	logic [SQRT_CNT_BITS-1:0] sq_cnt_q;
	logic                     out_valid_q;

	snap_t                    snap_q;
	logic [PROD_BITS-1:0]     acc_a_q;
	logic [PROD_BITS-1:0]     acc_b_q;
	logic [DIV_BITS-1:0]      nsq_q;
	logic [PROD_BITS-1:0]     diff_q;
	logic [DELAY_BITS-1:0]    mean_q;
	logic [QUO_BITS-1:0]      rad_q;
	logic [SREM_BITS-1:0]     srem_q;
	logic [DELAY_BITS-1:0]    root_q;

	logic                     mul_issue;
	logic                     out_load;
	logic [MUL_BITS-1:0]      opa;
	logic [MUL_BITS-1:0]      opb;
	logic [SREM_BITS+1:0]     sq_shift;
	logic [SREM_BITS+1:0]     sq_trial;
	logic [SREM_BITS+1:0]     sq_diff;
	logic                     sq_ge;

	logic [OUT_COUNT_BITS-1:0] sent_q;
	logic [OUT_COUNT_BITS-1:0] recv_q;
	logic [OUT_DELAY_BITS-1:0] min_q;
	logic [OUT_DELAY_BITS-1:0] max_q;
	logic [OUT_DELAY_BITS-1:0] mean_out_q;
	logic [OUT_DELAY_BITS-1:0] sd_out_q;

	assign pop       = (state_q == ST_IDLE) && !empty;
	assign mul_issue = (state_q == ST_MUL) && (mul_idx_q != MUL_END);
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Select multiplier operands
	always_comb begin
		case (mul_idx_q)
			MUL_A_LO: begin
				opa = MUL_BITS'(snap_q.recv);
				opb = snap_q.sq_sum[MUL_BITS-1:0];
			end
			MUL_A_HI: begin
				opa = MUL_BITS'(snap_q.recv);
				opb = snap_q.sq_sum[SQ_BITS-1:MUL_BITS];
			end
			MUL_B_LL: begin
				opa = MUL_BITS'(snap_q.sum[HALF_BITS-1:0]);
				opb = MUL_BITS'(snap_q.sum[HALF_BITS-1:0]);
			end
			MUL_B_LH: begin
				opa = MUL_BITS'(snap_q.sum[HALF_BITS-1:0]);
				opb = MUL_BITS'(snap_q.sum[SUM_BITS-1:HALF_BITS]);
			end
			MUL_B_HH: begin
				opa = MUL_BITS'(snap_q.sum[SUM_BITS-1:HALF_BITS]);
				opb = MUL_BITS'(snap_q.sum[SUM_BITS-1:HALF_BITS]);
			end
			MUL_NSQ: begin
				opa = MUL_BITS'(snap_q.recv);
				opb = MUL_BITS'(snap_q.recv);
			end
			default: begin
				opa = '0;
				opb = '0;
			end
		endcase
	end

	// Start the mean divide, then the variance divide when the mean is in
	always_comb begin
		div_req = '0;
		if (state_q == ST_SUB) begin
			div_req.start    = 1'b1;
			div_req.rem_init = DIV_BITS'(snap_q.sum[SUM_BITS-1:DELAY_BITS]);
			div_req.dividend = {snap_q.sum[DELAY_BITS-1:0], (QUO_BITS - DELAY_BITS)'(0)};
			div_req.divisor  = DIV_BITS'(snap_q.recv);
			div_req.steps    = DIV_CNT_BITS'(DELAY_BITS);
		end else if ((state_q == ST_MEAN) && div_rsp.done) begin
			div_req.start    = 1'b1;
			div_req.rem_init = diff_q[PROD_BITS-1:QUO_BITS];
			div_req.dividend = diff_q[QUO_BITS-1:0];
			div_req.divisor  = nsq_q;
			div_req.steps    = DIV_CNT_BITS'(QUO_BITS);
		end
	end

	// One step of the digit-by-digit square root
	assign sq_shift = {srem_q, rad_q[QUO_BITS-1:QUO_BITS-2]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_ge    = (sq_shift >= sq_trial);
	assign sq_diff  = sq_shift - sq_trial;

	// Sequencer and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			mul_idx_q   <= '0;
			pv_s1       <= 1'b0;
			sq_cnt_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			pv_s1 <= mul_issue;
			case (state_q)
				ST_IDLE: begin
					mul_idx_q <= '0;
					if (!empty) begin
						state_q <= (rd_data.recv == '0) ? ST_DONE : ST_MUL;
					end
				end
				ST_MUL: begin
					mul_idx_q <= mul_idx_q + 1'b1;
					if (mul_idx_q == MUL_END) begin
						state_q <= ST_SUB;
					end
				end
				ST_SUB: begin
					state_q <= ST_MEAN;
				end
				ST_MEAN: begin
					if (div_rsp.done) begin
						state_q <= ST_VAR;
					end
				end
				ST_VAR: begin
					sq_cnt_q <= '0;
					if (div_rsp.done) begin
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					sq_cnt_q <= sq_cnt_q + 1'b1;
					if (sq_cnt_q == SQRT_LAST) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// Hold the result until it is transferred
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (pop) begin
			snap_q <= rd_data;
			mean_q <= '0;
			root_q <= '0;
		end
		// Multiply, then accumulate in the next cycle
		if (mul_issue) begin
			prod_s1 <= opa * opb;
			tag_s1  <= mul_idx_q;
		end
		if (pv_s1) begin
			case (tag_s1)
				MUL_A_LO: acc_a_q <= PROD_BITS'(prod_s1);
				MUL_A_HI: acc_a_q <= acc_a_q + (PROD_BITS'(prod_s1) << MUL_BITS);
				MUL_B_LL: acc_b_q <= PROD_BITS'(prod_s1);
				MUL_B_LH: acc_b_q <= acc_b_q + (PROD_BITS'(prod_s1) << (HALF_BITS + 1));
				MUL_B_HH: acc_b_q <= acc_b_q + (PROD_BITS'(prod_s1) << SUM_BITS);
				MUL_NSQ:  nsq_q   <= prod_s1[DIV_BITS-1:0];
				default: begin
				end
			endcase
		end
		// Clamp a negative variance term to zero
		if (state_q == ST_SUB) begin
			diff_q <= (acc_a_q >= acc_b_q) ? (acc_a_q - acc_b_q) : '0;
		end
		if ((state_q == ST_MEAN) && div_rsp.done) begin
			mean_q <= div_rsp.quot[DELAY_BITS-1:0];
		end
		if ((state_q == ST_VAR) && div_rsp.done) begin
			rad_q  <= div_rsp.quot;
			srem_q <= '0;
			root_q <= '0;
		end
		if (state_q == ST_SQRT) begin
			srem_q <= sq_ge ? sq_diff[SREM_BITS-1:0] : sq_shift[SREM_BITS-1:0];
			root_q <= {root_q[DELAY_BITS-2:0], sq_ge};
			rad_q  <= {rad_q[QUO_BITS-3:0], 2'b00};
		end
		// Load the output register
		if (out_load) begin
			sent_q     <= snap_q.sent[OUT_COUNT_BITS-1:0];
			recv_q     <= snap_q.recv[OUT_COUNT_BITS-1:0];
			min_q      <= OUT_DELAY_BITS'(snap_q.min_d);
			max_q      <= OUT_DELAY_BITS'(snap_q.max_d);
			mean_out_q <= OUT_DELAY_BITS'(mean_q);
			sd_out_q   <= OUT_DELAY_BITS'(root_q);
		end
	end

	assign out_valid       = out_valid_q;
	assign sent_count      = sent_q;
	assign received_count  = recv_q;
	assign min_delay_us    = min_q;
	assign max_delay_us    = max_q;
	assign mean_delay_us   = mean_out_q;
	assign stddev_delay_us = sd_out_q;

`ifndef NO_ASSERTIONS
	a_div_start_free: assert property (@(posedge clk) disable iff (!arst_n)
		div_req.start |-> !div_rsp.busy) else $error("divider started while busy");
	a_div_done_awaited: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> (state_q == ST_MEAN || state_q == ST_VAR))
		else $error("divider finished with no sequencer waiting");
`endif

endmodule

// File: bench/tb_round_trip_time_statistics.sv
`timescale 1ns / 1ps
// Self-checking bench for the round-trip time statistics block: event stimulus, predictor, result checks.
module tb_round_trip_time_statistics;
	import rtts_pkg::*;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
	localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
	localparam logic [DELAY_BITS-1:0] DELAY_MAX = '1;

	localparam int RANDOM_EVENTS = 1000;
	localparam int PAUSE_MAX     = 16;
	localparam int DRAIN_CYCLES  = 300;
	localparam int IDLE_LIMIT    = 5000;

	// Delay distributions for the random part
	typedef enum int {SPREAD_FULL, SPREAD_SMALL, SPREAD_TIGHT, SPREAD_EDGES} spread_t;

	typedef struct {
		logic                  kind;
		logic [DELAY_BITS-1:0] delay;
	} probe_event_t;

	typedef struct packed {
		logic [OUT_COUNT_BITS-1:0] sent;
		logic [OUT_COUNT_BITS-1:0] recv;
		logic [OUT_DELAY_BITS-1:0] min_d;
		logic [OUT_DELAY_BITS-1:0] max_d;
		logic [OUT_DELAY_BITS-1:0] mean;
		logic [OUT_DELAY_BITS-1:0] sd;
	} rtt_stats_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                      in_valid  = 1'b0;
	logic                      in_stall;
	logic                      kind      = KIND_REQUEST;
	logic [DELAY_BITS-1:0]     delay_us  = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	logic [OUT_COUNT_BITS-1:0] sent_count;
	logic [OUT_COUNT_BITS-1:0] received_count;
	logic [OUT_DELAY_BITS-1:0] min_delay_us;
	logic [OUT_DELAY_BITS-1:0] max_delay_us;
	logic [OUT_DELAY_BITS-1:0] mean_delay_us;
	logic [OUT_DELAY_BITS-1:0] stddev_delay_us;

	probe_event_t pending_events[$];
	rtt_stats_t   stats_expected[$];

	// Predictor state
	logic [COUNT_BITS-1:0] tally_sent   = '0;
	logic [COUNT_BITS-1:0] tally_recv   = '0;
	logic [DELAY_BITS-1:0] low_delay    = '0;
	logic [DELAY_BITS-1:0] high_delay   = '0;
	logic [SUM_BITS-1:0]   delay_total  = '0;
	logic [SQ_BITS-1:0]    square_total = '0;

	int mismatches      = 0;
	int events_taken    = 0;
	int replies_taken   = 0;
	int results_checked = 0;
	int idle_cycles     = 0;

	bit in_burst  = 1'b0;
	bit out_burst = 1'b0;
	int in_pause  = 0;
	int out_pause = 0;

	probe_event_t next_event;
	rtt_stats_t   predicted;
	rtt_stats_t   oldest;
	rtt_stats_t   observed;

	round_trip_time_statistics i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.kind            (kind),
		.delay_us        (delay_us),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.sent_count      (sent_count),
		.received_count  (received_count),
		.min_delay_us    (min_delay_us),
		.max_delay_us    (max_delay_us),
		.mean_delay_us   (mean_delay_us),
		.stddev_delay_us (stddev_delay_us)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [63:0] int_sqrt(input logic [63:0] value);
		logic [63:0] rest;
		logic [63:0] root;
		logic [63:0] probe;
		rest  = value;
		root  = '0;
		probe = 64'h1 << 62;
		while (probe > rest)
			probe = probe >> 2;
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	// Fold one event into the running statistics and report the new snapshot
	task automatic fold_event(input logic ev_kind, input logic [DELAY_BITS-1:0] d,
			output rtt_stats_t r);
		logic [SUM_BITS:0] sum_next;
		logic [SQ_BITS:0]  square_next;
		logic [127:0]      scaled_squares;
		logic [127:0]      squared_sum;
		logic [127:0]      variance;
		if (ev_kind == KIND_REQUEST) begin
			if (tally_sent != COUNT_MAX)
				tally_sent = tally_sent + 1'b1;
		end else begin
			replies_taken++;
			// first reply seeds both extremes, zero included
			if (tally_recv == 0) begin
				low_delay  = d;
				high_delay = d;
			end else begin
				if (d < low_delay)
					low_delay = d;
				if (d > high_delay)
					high_delay = d;
			end
			// a saturated count freezes the sums
			if (tally_recv != COUNT_MAX) begin
				tally_recv   = tally_recv + 1'b1;
				sum_next     = {1'b0, delay_total} + (SUM_BITS + 1)'(d);
				delay_total  = (sum_next > {1'b0, SUM_MAX}) ? SUM_MAX : sum_next[SUM_BITS-1:0];
				square_next  = {1'b0, square_total} + (SQ_BITS + 1)'(d) * (SQ_BITS + 1)'(d);
				square_total = square_next[SQ_BITS] ? '1 : square_next[SQ_BITS-1:0];
			end
		end
		r.sent  = OUT_COUNT_BITS'(tally_sent);
		r.recv  = OUT_COUNT_BITS'(tally_recv);
		r.min_d = OUT_DELAY_BITS'(low_delay);
		r.max_d = OUT_DELAY_BITS'(high_delay);
		r.mean  = '0;
		r.sd    = '0;
		if (tally_recv != 0) begin
			r.mean         = OUT_DELAY_BITS'(delay_total / SUM_BITS'(tally_recv));
			scaled_squares = 128'(tally_recv) * 128'(square_total);
			squared_sum    = 128'(delay_total) * 128'(delay_total);
			// a negative variance term reads as zero
			if (scaled_squares >= squared_sum) begin
				variance = (scaled_squares - squared_sum) /
					(128'(tally_recv) * 128'(tally_recv));
				r.sd = OUT_DELAY_BITS'(int_sqrt(variance[63:0]));
			end
		end
	endtask

	function automatic int draw_pause(input bit burst);
		return burst ? 0 : $urandom_range(0, PAUSE_MAX);
	endfunction

	function automatic logic [DELAY_BITS-1:0] draw_delay(input spread_t spread,
			input logic [DELAY_BITS-1:0] centre);
		case (spread)
			SPREAD_SMALL: return DELAY_BITS'($urandom_range(0, 255));
			SPREAD_TIGHT: return centre + DELAY_BITS'($urandom_range(0, 31));
			SPREAD_EDGES: begin
				case ($urandom_range(0, 3))
					0:       return '0;
					1:       return DELAY_BITS'(1);
					2:       return DELAY_MAX - 1'b1;
					default: return DELAY_MAX;
				endcase
			end
			default: return DELAY_BITS'($urandom);
		endcase
	endfunction

	task automatic queue_event(input logic ev_kind, input logic [DELAY_BITS-1:0] d);
		probe_event_t ev;
		ev.kind  = ev_kind;
		ev.delay = d;
		pending_events.push_back(ev);
	endtask

	function automatic void check_field(input string name, input logic [23:0] want,
			input logic [23:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endfunction

	// Input driver: present queued events, pausing between transfers
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			kind     <= KIND_REQUEST;
			delay_us <= '0;
		end else begin
			if (in_valid && !in_stall) begin
				fold_event(kind, delay_us, predicted);
				stats_expected.push_back(predicted);
				events_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (in_pause != 0) begin
					in_pause = in_pause - 1;
					in_valid <= 1'b0;
				end else if (pending_events.size() != 0) begin
					next_event = pending_events.pop_front();
					kind     <= next_event.kind;
					delay_us <= next_event.delay;
					in_valid <= 1'b1;
					if ($urandom_range(0, 7) == 0)
						in_burst = !in_burst;
					in_pause = draw_pause(in_burst);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: check each transfer, then stall the next one for a drawn number of cycles
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (out_valid && !out_stall) begin
			observed = '{sent_count, received_count, min_delay_us, max_delay_us,
				mean_delay_us, stddev_delay_us};
			if (stats_expected.size() == 0) begin
				$error("unexpected result transfer: sent %0d received %0d",
					sent_count, received_count);
				mismatches++;
			end else begin
				oldest = stats_expected.pop_front();
				check_field("sent_count", 24'(oldest.sent), 24'(observed.sent));
				check_field("received_count", 24'(oldest.recv), 24'(observed.recv));
				check_field("min_delay_us", oldest.min_d, observed.min_d);
				check_field("max_delay_us", oldest.max_d, observed.max_d);
				check_field("mean_delay_us", oldest.mean, observed.mean);
				check_field("stddev_delay_us", oldest.sd, observed.sd);
				results_checked++;
			end
			if ($urandom_range(0, 7) == 0)
				out_burst = !out_burst;
			out_pause = draw_pause(out_burst);
			out_stall <= (out_pause != 0);
		end else if (out_valid) begin
			// count down stall cycles only while a result waits
			if (out_pause > 0)
				out_pause = out_pause - 1;
			out_stall <= (out_pause != 0);
		end else begin
			out_stall <= (out_pause != 0);
		end
	end

	// Watchdog: end the run when no transfer happens for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("round_trip_time_statistics regression: fail");
				$finish;
			end
		end
	end

	initial begin
		spread_t               spread;
		logic [DELAY_BITS-1:0] centre;

		// Directed part: requests before any reply, zero as first reply, extremes
		queue_event(KIND_REQUEST, DELAY_MAX);
		queue_event(KIND_REQUEST, '0);
		queue_event(KIND_REPLY, '0);
		queue_event(KIND_REPLY, DELAY_MAX);
		queue_event(KIND_REPLY, DELAY_BITS'(1));
		queue_event(KIND_REQUEST, 24'h5A5A5A);
		queue_event(KIND_REPLY, DELAY_MAX);
		queue_event(KIND_REPLY, 24'h800000);
		queue_event(KIND_REPLY, 24'h7FFFFF);
		queue_event(KIND_REPLY, 24'hAAAAAA);
		queue_event(KIND_REPLY, 24'h555555);
		queue_event(KIND_REPLY, '0);
		queue_event(KIND_REQUEST, 24'hA5A5A5);
		queue_event(KIND_REPLY, DELAY_MAX - 1'b1);
		queue_event(KIND_REQUEST, DELAY_MAX);
		queue_event(KIND_REPLY, 24'h000100);

		// Random part: runs of replies drawn from changing delay distributions
		spread = SPREAD_FULL;
		centre = '0;
		for (int i = 0; i < RANDOM_EVENTS; i++) begin
			if (i % 50 == 0) begin
				spread = spread_t'($urandom_range(0, 3));
				centre = DELAY_BITS'($urandom_range(0, 24'hFFFFE0));
			end
			if ($urandom_range(0, 3) == 0)
				queue_event(KIND_REQUEST, DELAY_BITS'($urandom));
			else
				queue_event(KIND_REPLY, draw_delay(spread, centre));
		end

		// Hold reset, then release away from the rising edge
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (pending_events.size() != 0 || in_valid || stats_expected.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("covered %0d events (%0d replies, %0d requests) with random pauses on both sides",
			events_taken, replies_taken, events_taken - replies_taken);
		$display("checked %0d result transfers, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && stats_expected.size() == 0)
			$display("round_trip_time_statistics regression: pass");
		else
			$display("round_trip_time_statistics regression: fail");
		$finish;
	end

endmodule
